### hdl/mck_pkg.sv
package mck_pkg;

    localparam int UNIT_W = 10;
    localparam int DUR_W  = 12;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 10'd50;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] CASE_MASK     = 8'hDF;

    // One segment as the sequencer requests it; the top level scales it by the unit.
    typedef struct packed {
        logic pin;
        logic triple;
        logic unk;
        logic last;
    } seg_t;

    // Code entry: {element count, pattern}; pattern bit 0 is sent first, 1 = dash.
    typedef logic [7:0] code_t;

    localparam code_t ALPHA_TABLE [26] = '{
        {3'd2, 5'b00010}, // A .-
        {3'd4, 5'b00001}, // B -...
        {3'd4, 5'b00101}, // C -.-.
        {3'd3, 5'b00001}, // D -..
        {3'd1, 5'b00000}, // E .
        {3'd4, 5'b00100}, // F ..-.
        {3'd3, 5'b00011}, // G --.
        {3'd4, 5'b00000}, // H ....
        {3'd2, 5'b00000}, // I ..
        {3'd4, 5'b01110}, // J .---
        {3'd3, 5'b00101}, // K -.-
        {3'd4, 5'b00010}, // L .-..
        {3'd2, 5'b00011}, // M --
        {3'd2, 5'b00001}, // N -.
        {3'd3, 5'b00111}, // O ---
        {3'd4, 5'b00110}, // P .--.
        {3'd4, 5'b01011}, // Q --.-
        {3'd3, 5'b00010}, // R .-.
        {3'd3, 5'b00000}, // S ...
        {3'd1, 5'b00001}, // T -
        {3'd3, 5'b00100}, // U ..-
        {3'd4, 5'b01000}, // V ...-
        {3'd3, 5'b00110}, // W .--
        {3'd4, 5'b01001}, // X -..-
        {3'd4, 5'b01101}, // Y -.--
        {3'd4, 5'b00011}  // Z --..
    };

    localparam code_t DIGIT_TABLE [10] = '{
        {3'd5, 5'b11111}, // 0
        {3'd5, 5'b11110}, // 1
        {3'd5, 5'b11100}, // 2
        {3'd5, 5'b11000}, // 3
        {3'd5, 5'b10000}, // 4
        {3'd5, 5'b00000}, // 5
        {3'd5, 5'b00001}, // 6
        {3'd5, 5'b00011}, // 7
        {3'd5, 5'b00111}, // 8
        {3'd5, 5'b01111}  // 9
    };

endpackage

### hdl/mck_seq.sv
module mck_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [7:0]     char_code,
    input  logic           advance,
    output logic           busy,
    output mck_pkg::seg_t  seg
);

    typedef enum logic [1:0] {DUR_UNIT, DUR_TRIPLE, DUR_ELEM} dur_sel_t;
    typedef enum logic [1:0] {BR_NEXT, BR_LOOP, BR_END} branch_t;

    typedef struct packed {
        logic      pin;
        dur_sel_t  dur;
        logic      unk;
        logic      last;
        branch_t   br;
        logic [2:0] target;
    } ucode_t;

    localparam logic [2:0] U_ELEM_ON  = 3'd0;
    localparam logic [2:0] U_ELEM_GAP = 3'd1;
    localparam logic [2:0] U_CHAR_END = 3'd2;
    localparam logic [2:0] U_SPACE    = 3'd3;
    localparam logic [2:0] U_UNKNOWN  = 3'd4;

    function automatic ucode_t rom(input logic [2:0] addr);
        ucode_t w;
        unique case (addr)
            U_ELEM_ON:  w = '{1'b0, DUR_ELEM,   1'b0, 1'b0, BR_NEXT, U_ELEM_ON};
            U_ELEM_GAP: w = '{1'b1, DUR_UNIT,   1'b0, 1'b0, BR_LOOP, U_ELEM_ON};
            U_CHAR_END: w = '{1'b1, DUR_TRIPLE, 1'b0, 1'b1, BR_END,  U_ELEM_ON};
            U_SPACE:    w = '{1'b1, DUR_TRIPLE, 1'b0, 1'b1, BR_END,  U_ELEM_ON};
            default:    w = '{1'b1, DUR_UNIT,   1'b1, 1'b1, BR_END,  U_ELEM_ON};
        endcase
        return w;
    endfunction

    logic       busy_reg, busy_next;
    logic [2:0] pc_reg, pc_next;
    logic [4:0] pat_reg, pat_next;
    logic [2:0] count_reg, count_next;

    ucode_t     uw;
    logic       is_upper, is_lower, is_digit;
    logic [7:0] alpha_off, digit_off;
    mck_pkg::code_t entry;
    logic [2:0] count_dec;

    always_comb begin
        is_upper  = (char_code >= mck_pkg::ASCII_UPPER_A) && (char_code <= mck_pkg::ASCII_UPPER_Z);
        is_lower  = (char_code >= mck_pkg::ASCII_LOWER_A) && (char_code <= mck_pkg::ASCII_LOWER_Z);
        is_digit  = (char_code >= mck_pkg::ASCII_ZERO) && (char_code <= mck_pkg::ASCII_NINE);
        alpha_off = (char_code & mck_pkg::CASE_MASK) - mck_pkg::ASCII_UPPER_A;
        digit_off = char_code - mck_pkg::ASCII_ZERO;
        entry     = is_digit ? mck_pkg::DIGIT_TABLE[digit_off[3:0]]
                             : mck_pkg::ALPHA_TABLE[alpha_off[4:0]];
    end

    always_comb begin
        uw         = rom(pc_reg);
        count_dec  = count_reg - 3'd1;
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        pat_next   = pat_reg;
        count_next = count_reg;

        if (!busy_reg) begin
            if (start) begin
                busy_next  = 1'b1;
                pat_next   = entry[4:0];
                count_next = entry[7:5];
                if (is_upper || is_lower || is_digit) begin
                    pc_next = U_ELEM_ON;
                end else if (char_code == mck_pkg::ASCII_SPACE) begin
                    pc_next = U_SPACE;
                end else begin
                    pc_next = U_UNKNOWN;
                end
            end
        end else if (advance) begin
            unique case (uw.br)
                BR_NEXT: pc_next = pc_reg + 3'd1;
                BR_LOOP: begin
                    count_next = count_dec;
                    pat_next   = pat_reg >> 1;
                    pc_next    = (count_dec != 3'd0) ? uw.target : pc_reg + 3'd1;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= U_ELEM_ON;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
        pat_reg   <= pat_next;
        count_reg <= count_next;
    end

    always_comb begin
        seg.pin    = uw.pin;
        seg.triple = (uw.dur == DUR_TRIPLE) || ((uw.dur == DUR_ELEM) && pat_reg[0]);
        seg.unk    = uw.unk;
        seg.last   = uw.last;
    end

    assign busy = busy_reg;

endmodule

### hdl/morse_character_keyer.sv
// Morse character keyer. Each accepted byte on the s_ channel becomes one
// to eleven timed keying segments on the m_ channel, one beat per segment:
// pin level 0 keys. Letters (either case) and digits send their Morse code,
// each element followed by a one-unit gap and the character closed by a
// three-unit gap; a space sends one three-unit gap; any other byte sends a
// one-unit gap with tuser set. unit_time is written through cfg_wr_en /
// cfg_wr_data (reset 50) and must only change while the block is idle.
// A character of n elements yields 2n+1 segments from the microcode step
// counter, one segment per cycle while the output side does not stall; a new
// byte is taken once the step counter has issued the last segment of the
// previous one.
module morse_character_keyer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,   // unit_time
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [0] pin_level, [12:1] duration, [15:13] zero
    output logic        m_tuser,       // [0] unknown_char
    output logic        m_tlast        // last_segment
);

    logic [mck_pkg::UNIT_W-1:0] unit_reg;
    logic                       m_valid_reg;
    logic                       pin_reg;
    logic [mck_pkg::DUR_W-1:0]  dur_reg, dur_next;
    logic                       unk_reg;
    logic                       last_reg;

    logic          busy;
    logic          advance;
    mck_pkg::seg_t seg;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !busy;

    mck_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid),
        .char_code (s_tdata),
        .advance   (advance),
        .busy      (busy),
        .seg       (seg)
    );

    // 3u = 2u + u
    always_comb begin
        if (seg.triple) begin
            dur_next = {1'b0, unit_reg, 1'b0} + {2'b00, unit_reg};
        end else begin
            dur_next = {2'b00, unit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg    <= mck_pkg::UNIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unit_reg <= cfg_wr_data;
            end
            if (busy && advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (busy && advance) begin
            pin_reg  <= seg.pin;
            dur_reg  <= dur_next;
            unk_reg  <= seg.unk;
            last_reg <= seg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, dur_reg, pin_reg};
    assign m_tuser  = unk_reg;
    assign m_tlast  = last_reg;

endmodule

### hdl/mck_checker.sv
module mck_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // every byte yields at least one segment, so input closes right after a beat
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after taking a byte");

    a_unknown_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[0])
        else $error("unknown byte not sent as one open segment");

    // a keyed segment is always followed by a gap
    a_key_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> !m_tlast && !m_tuser)
        else $error("keyed segment marked last");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:13] == 3'b000)
        else $error("tdata padding not zero");

endmodule

bind morse_character_keyer mck_checker u_mck_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
